>>> rtl/ccio_pkg.sv
// Package for the coin and credit I/O controller.
// Holds field widths, operation and command codes, and the LFSR constants.
// No dependencies.
package ccio_pkg;

  localparam int InWidth  = 48;
  localparam int OutWidth = 24;

  typedef logic [3:0] nib_t;

  // Host operations
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_RUN   = 3'd2;
  localparam logic [2:0] FUNC_RSTON = 3'd3;
  localparam logic [2:0] FUNC_RSTOF = 3'd4;

  // Chip variants
  localparam logic [1:0] CHIP_56 = 2'd0;
  localparam logic [1:0] CHIP_58 = 2'd1;
  localparam logic [1:0] CHIP_59 = 2'd2;

  // Command codes held in nibble 8
  localparam nib_t CMD56_SWITCH = 4'd1;
  localparam nib_t CMD56_COINAGE = 4'd2;
  localparam nib_t CMD56_COINS  = 4'd4;
  localparam nib_t CMD56_BOOT   = 4'd7;
  localparam nib_t CMD56_CSUM   = 4'd8;
  localparam nib_t CMD56_DIPS   = 4'd9;
  localparam nib_t CMD58_SWITCH = 4'd1;
  localparam nib_t CMD58_COINAGE = 4'd2;
  localparam nib_t CMD58_COINS  = 4'd3;
  localparam nib_t CMD58_DIPS   = 4'd4;
  localparam nib_t CMD58_LFSR   = 4'd5;
  localparam nib_t CMD59_PORTS  = 4'd3;

  // Fixed boot answer nibbles
  localparam nib_t BOOT_NIB2 = 4'hE;
  localparam nib_t BOOT_NIB7 = 4'h6;

  // LFSR check
  localparam logic [7:0] LFSR_SEED = 8'h22;
  localparam logic [7:0] LFSR_POLY = 8'h90;

  // Memory nibble used as the tap of mix step j
  function automatic logic [3:0] lfsr_tap(input logic [2:0] j);
    case (j)
      3'd0:    lfsr_tap = 4'd11;
      3'd1:    lfsr_tap = 4'd10;
      3'd2:    lfsr_tap = 4'd9;
      3'd3:    lfsr_tap = 4'd15;
      3'd4:    lfsr_tap = 4'd14;
      3'd5:    lfsr_tap = 4'd13;
      default: lfsr_tap = 4'd12;
    endcase
  endfunction

endpackage

>>> rtl/ccio_lfsr.sv
// Shared LFSR step unit of the boot check.
// Depends on ccio_pkg for the feedback polynomial.
module ccio_lfsr
  import ccio_pkg::*;
(
  input  logic [7:0] cur,
  output logic [7:0] nxt
);

  logic [7:0] fb;

  // Fold in the polynomial on a set low bit, then shift right
  assign fb  = cur[0] ? (cur ^ LFSR_POLY) : cur;
  assign nxt = {1'b0, fb[7:1]};

endmodule

>>> rtl/coin_credit_io_controller_top.sv
// Top level of the coin and credit I/O controller: sequencer, shared memory
// and coin logic. Depends on ccio_pkg and ccio_lfsr.
//
// A request passes from acceptance to result through accept, execute and
// present, plus any wait for the result to be taken. The LFSR boot check
// runs between execute and present, all in the single shared LFSR step
// unit: cnt steps to advance the seed, cnt = {nibble 9, nibble 10} masked
// to 7 bits, and then seven mixes of seven steps each. A new request is
// taken only while the sequencer is idle.
module coin_credit_io_controller_top
  import ccio_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data,   // chip_type
  input  logic                s_tvalid,
  output logic                s_tready,
  // func[2:0] offset[6:3] wdata[10:7] port_a[18:11] port_b[26:19]
  // port_c[34:27] port_d[42:35]
  input  logic [InWidth-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // rdata[7:0] out_a_valid[8] out_a[12:9] out_b_valid[13] out_b[17:14]
  // reset_flag[18]
  output logic [OutWidth-1:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LSKIP, ST_LMIX, ST_PUSH
  } state_t;

  state_t state;

  logic [1:0] chip_type;
  nib_t       mem [16];
  logic       reset_line;
  nib_t       last_coin, last_button;
  logic [7:0] credit;
  nib_t       tally [2];
  nib_t       cpc [2];    // coins per credit
  nib_t       cpcr [2];   // credits per coin

  // Latched request
  logic [2:0] func;
  nib_t       offset, wdata;
  logic [7:0] port_a, port_b, port_c, port_d;

  // Held result
  logic [7:0] res_rdata;
  logic       res_av, res_bv;
  nib_t       res_a, res_b;

  // LFSR sequencer
  logic [6:0] cnt;
  logic [7:0] seed, rng;
  logic [2:0] mix_i, mix_j;
  nib_t       acc;
  logic [7:0] lfsr_in, lfsr_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  assign lfsr_in = (state == ST_LSKIP) ? seed : rng;

  ccio_lfsr u_lfsr (
    .cur (lfsr_in),
    .nxt (lfsr_out)
  );

  // Coin and button handling
  nib_t        val_c, edge_c, val_b, edge_b;
  nib_t        t_k [2];
  nib_t        tally_new [2];
  logic [4:0]  add_k [2];
  logic        hit [2];
  logic [4:0]  add;
  logic [1:0]  sub;
  logic [9:0]  csum;
  logic [7:0]  credit_new;
  logic [15:0] prod;
  logic [4:0]  tens;
  logic [7:0]  ones;
  logic [6:0]  chk;

  always_comb begin
    val_c  = ~port_a[3:0];
    edge_c = val_c & (val_c ^ last_coin);
    for (int k = 0; k < 2; k++) begin
      t_k[k] = tally[k] + 4'd1;
      hit[k] = (t_k[k] >= {1'b0, cpc[k][2:0]});
      if (hit[k]) begin
        tally_new[k] = t_k[k] - {1'b0, cpc[k][2:0]};
        add_k[k]     = {1'b0, cpcr[k]} - {4'd0, cpc[k][3]};
      end else begin
        tally_new[k] = t_k[k];
        add_k[k]     = {4'd0, cpc[k][3]};
      end
    end
    add = 5'd0;
    if (edge_c[0]) add = add_k[0];
    if (edge_c[1]) add = add_k[1];
    if (edge_c[3]) add = 5'd1;

    val_b  = ~port_d[3:0];
    edge_b = val_b & (val_b ^ last_button);
    sub    = 2'd0;
    if (mem[9] == 4'd0) begin
      if (edge_b[2]) begin
        if (credit >= 8'd1) sub = 2'd1;
      end else if (edge_b[3]) begin
        if (credit >= 8'd2) sub = 2'd2;
      end
    end

    csum = {2'b00, credit} + {{5{add[4]}}, add} - {8'd0, sub};
    if (csum[9])         credit_new = 8'd0;
    else if (csum[8])    credit_new = 8'hFF;
    else                 credit_new = csum[7:0];

    // Split into decimal digits by reciprocal multiply
    prod = {8'd0, credit_new} * 16'd205;
    tens = prod[15:11];
    ones = credit_new - ({3'd0, tens} * 8'd10);

    chk = {3'd0, mem[9]} + {3'd0, mem[10]} + {3'd0, mem[11]} + {3'd0, mem[12]}
        + {3'd0, mem[13]} + {3'd0, mem[14]} + {3'd0, mem[15]};
  end

  // Mix step of the LFSR check
  nib_t acc_n;
  assign acc_n = rng[0] ? (acc ^ ~mem[lfsr_tap(mix_j)]) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chip_type   <= CHIP_56;
      m_tvalid    <= 1'b0;
      reset_line  <= 1'b0;
      last_coin   <= 4'd0;
      last_button <= 4'd0;
      credit      <= 8'd0;
      for (int k = 0; k < 2; k++) begin
        tally[k] <= 4'd0;
        cpc[k]   <= 4'd1;
        cpcr[k]  <= 4'd1;
      end
      for (int m = 0; m < 16; m++) mem[m] <= 4'd0;
    end else begin
      if (cfg_valid) chip_type <= cfg_data;
      if (m_tvalid && m_tready && state != ST_PUSH) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          // Latch the request and clear the result fields
          if (s_tvalid) begin
            func      <= s_tdata[2:0];
            offset    <= s_tdata[6:3];
            wdata     <= s_tdata[10:7];
            port_a    <= s_tdata[18:11];
            port_b    <= s_tdata[26:19];
            port_c    <= s_tdata[34:27];
            port_d    <= s_tdata[42:35];
            res_rdata <= 8'd0;
            res_av    <= 1'b0;
            res_a     <= 4'd0;
            res_bv    <= 1'b0;
            res_b     <= 4'd0;
            state     <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          // Execute the operation, then branch to the LFSR sequence or present the result
          state <= (func == FUNC_RUN && chip_type == CHIP_58 && mem[8] == CMD58_LFSR) ?
                   ST_LSKIP : ST_PUSH;
          case (func)
            FUNC_WRITE: mem[offset] <= wdata;
            FUNC_READ:  res_rdata <= {4'hF, mem[offset]};
            FUNC_RUN: begin
              case (chip_type)
                CHIP_56: begin
                  case (mem[8])
                    CMD56_SWITCH: begin
                      mem[0] <= ~port_a[3:0];
                      mem[1] <= ~port_b[3:0];
                      mem[2] <= ~port_c[3:0];
                      mem[3] <= ~port_d[3:0];
                      res_av <= 1'b1; res_a <= mem[9];
                      res_bv <= 1'b1; res_b <= mem[10];
                    end
                    CMD56_COINAGE: begin
                      cpc[0] <= mem[9];  cpcr[0] <= mem[10];
                      cpc[1] <= mem[11]; cpcr[1] <= mem[12];
                    end
                    CMD56_COINS: begin
                      last_coin   <= val_c;
                      last_button <= val_b;
                      if (edge_c[0]) tally[0] <= tally_new[0];
                      if (edge_c[1]) tally[1] <= tally_new[1];
                      credit <= credit_new;
                      mem[0] <= tens[3:0];
                      mem[1] <= ones[3:0];
                      mem[2] <= add[3:0];
                      mem[3] <= {2'b00, sub};
                      mem[4] <= ~port_b[3:0];
                      mem[5] <= {val_b[2], 1'b0, val_b[0], 1'b0} | (edge_b & 4'h5);
                      mem[6] <= ~port_c[3:0];
                      mem[7] <= (val_b & 4'hA) | {1'b0, edge_b[3], 1'b0, edge_b[1]};
                    end
                    CMD56_BOOT: begin
                      mem[2] <= BOOT_NIB2;
                      mem[7] <= BOOT_NIB7;
                    end
                    CMD56_CSUM: begin
                      mem[0] <= {1'b0, chk[6:4]};
                      mem[1] <= chk[3:0];
                    end
                    CMD56_DIPS: begin
                      mem[0] <= ~port_a[3:0]; mem[1] <= ~port_a[7:4];
                      mem[2] <= ~port_b[3:0]; mem[3] <= ~port_b[7:4];
                      mem[4] <= ~port_c[3:0]; mem[5] <= ~port_c[7:4];
                      mem[6] <= ~port_d[3:0]; mem[7] <= ~port_d[7:4];
                      res_av <= 1'b1; res_a <= 4'd1;
                    end
                    default: ;
                  endcase
                end
                CHIP_58: begin
                  case (mem[8])
                    CMD58_SWITCH: begin
                      mem[4] <= ~port_a[3:0];
                      mem[5] <= ~port_b[3:0];
                      mem[6] <= ~port_c[3:0];
                      mem[7] <= ~port_d[3:0];
                      res_av <= 1'b1; res_a <= mem[9];
                      res_bv <= 1'b1; res_b <= mem[10];
                    end
                    CMD58_COINAGE: begin
                      cpc[0] <= mem[9];  cpcr[0] <= mem[10];
                      cpc[1] <= mem[11]; cpcr[1] <= mem[12];
                    end
                    CMD58_COINS: begin
                      last_coin   <= val_c;
                      last_button <= val_b;
                      if (edge_c[0]) tally[0] <= tally_new[0];
                      if (edge_c[1]) tally[1] <= tally_new[1];
                      credit <= credit_new;
                      mem[2] <= tens[3:0];
                      mem[3] <= ones[3:0];
                      mem[0] <= add[3:0];
                      mem[1] <= {2'b00, sub};
                      mem[4] <= ~port_b[3:0];
                      mem[5] <= {val_b[2], 1'b0, val_b[0], 1'b0} | (edge_b & 4'h5);
                      mem[6] <= ~port_c[3:0];
                      mem[7] <= (val_b & 4'hA) | {1'b0, edge_b[3], 1'b0, edge_b[1]};
                    end
                    CMD58_DIPS: begin
                      mem[0] <= ~port_a[3:0]; mem[1] <= ~port_a[7:4];
                      mem[2] <= ~port_b[3:0]; mem[3] <= ~port_b[7:4];
                      mem[4] <= ~port_c[3:0]; mem[5] <= ~port_c[7:4];
                      mem[6] <= ~port_d[3:0]; mem[7] <= ~port_d[7:4];
                      res_av <= 1'b1; res_a <= 4'd1;
                    end
                    CMD58_LFSR: begin
                      cnt   <= {mem[9][2:0], mem[10]};
                      seed  <= LFSR_SEED;
                    end
                    default: ;
                  endcase
                end
                CHIP_59: begin
                  if (mem[8] == CMD59_PORTS) begin
                    mem[4] <= ~port_a[3:0];
                    mem[5] <= ~port_c[3:0];
                    mem[6] <= ~port_b[3:0];
                    mem[7] <= ~port_d[3:0];
                  end
                end
                default: ;
              endcase
            end
            FUNC_RSTON: begin
              reset_line <= 1'b1;
              credit     <= 8'd0;
              for (int k = 0; k < 2; k++) begin
                tally[k] <= 4'd0;
                cpc[k]   <= 4'd1;
                cpcr[k]  <= 4'd1;
              end
            end
            FUNC_RSTOF: reset_line <= 1'b0;
            default: ;
          endcase
        end

        ST_LSKIP: begin
          // Advance the seed cnt times
          if (cnt != 7'd0) begin
            seed <= lfsr_out;
            cnt  <= cnt - 7'd1;
          end else begin
            rng   <= seed;
            mix_i <= 3'd1;
            mix_j <= 3'd0;
            acc   <= 4'd0;
            state <= ST_LMIX;
          end
        end

        ST_LMIX: begin
          // One tap per cycle, seven taps per output nibble
          if (mix_j == 3'd0) seed <= lfsr_out;
          if (mix_j != 3'd6) begin
            rng   <= lfsr_out;
            mix_j <= mix_j + 3'd1;
            acc   <= acc_n;
          end else begin
            mem[mix_i] <= ~acc_n;
            acc        <= 4'd0;
            mix_j      <= 3'd0;
            rng        <= seed;
            if (mix_i == 3'd7) begin
              mem[0] <= (mem[9] == 4'hF) ? 4'hF : 4'h0;
              state  <= ST_PUSH;
            end else begin
              mix_i <= mix_i + 3'd1;
            end
          end
        end

        ST_PUSH: begin
          // Load the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'd0, reset_line, res_b, res_bv, res_a, res_av, res_rdata};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ccio_checker.sv
// Port-level checker for the coin and credit I/O controller, with its bind.
// Depends on coin_credit_io_controller_top.
module ccio_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Drop ready while a request is at work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // Read data carries the high nibble set or is zero
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:4] == 4'hF))
    else $error("bad read data");

  // Undriven ports report zero
  a_ports: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] || m_tdata[12:9] == 4'd0) &&
                 (m_tdata[13] || m_tdata[17:14] == 4'd0))
    else $error("undriven port value not zero");

endmodule

bind coin_credit_io_controller_top ccio_checker u_ccio_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/coin_credit_io_controller_top_tb.sv
// Testbench for the coin and credit I/O controller: drives host requests,
// predicts each result in a local model and compares field by field.
// Depends on ccio_pkg and coin_credit_io_controller_top.
`timescale 1ns / 100ps

module coin_credit_io_controller_top_tb;
  import ccio_pkg::*;

  typedef struct packed {
    logic [7:0] port_d;
    logic [7:0] port_c;
    logic [7:0] port_b;
    logic [7:0] port_a;
    logic [3:0] wdata;
    logic [3:0] offset;
    logic [2:0] func;
  } host_req_t;

  typedef struct packed {
    logic       reset_flag;
    logic [3:0] out_b;
    logic       out_b_valid;
    logic [3:0] out_a;
    logic       out_a_valid;
    logic [7:0] rdata;
  } host_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InWidth-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  coin_credit_io_controller_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [1:0] variant;
  logic [3:0] mem [16];
  logic       line_rst;
  logic [3:0] prev_coins, prev_buttons;
  logic [7:0] credits;
  logic [3:0] tally [2];
  logic [3:0] coin_ratio [2];
  logic [3:0] credit_ratio [2];

  host_req_t  pending_reqs [$];
  host_resp_t expected_resps [$];
  int errors = 0;
  int resp_count = 0;
  bit quiet_phase = 0;
  bit long_hold = 0;
  bit stim_done = 0;
  int hold_cnt = 0;
  longint cycles = 0;
  int cmd_runs = 0;
  logic s_tready_q = 1'b0;

  function automatic logic [3:0] lo_pins(logic [7:0] p);
    return ~p[3:0];
  endfunction

  function automatic logic [3:0] hi_pins(logic [7:0] p);
    return ~p[7:4];
  endfunction

  function automatic logic [7:0] lfsr_step(logic [7:0] n);
    if (n[0]) n = n ^ LFSR_POLY;
    return n >> 1;
  endfunction

  function automatic void clear_coinage();
    credits = '0;
    for (int k = 0; k < 2; k++) begin
      tally[k] = '0;
      coin_ratio[k] = 4'd1;
      credit_ratio[k] = 4'd1;
    end
  endfunction

  function automatic int slot_credit(int k);
    int per;
    int add;
    per = coin_ratio[k] & 7;
    add = 0;
    tally[k] = tally[k] + 4'd1;
    if (tally[k] >= per) begin
      add = int'(credit_ratio[k]) - int'(coin_ratio[k][3]);
      tally[k] = tally[k] - per[3:0];
    end else if (coin_ratio[k][3]) begin
      add = 1;
    end
    return add;
  endfunction

  function automatic void update_coins(host_req_t r, logic [3:0] swap);
    logic [3:0] val, edg;
    int add, sub, c;
    add = 0;
    sub = 0;
    val = lo_pins(r.port_a);
    edg = val & (val ^ prev_coins);
    prev_coins = val;
    if (edg[0]) add = slot_credit(0);
    if (edg[1]) add = slot_credit(1);
    if (edg[3]) add = 1;
    val = lo_pins(r.port_d);
    edg = val & (val ^ prev_buttons);
    prev_buttons = val;
    if (mem[9] == 0) begin
      if (edg[2]) begin
        if (credits >= 1) sub = 1;
      end else if (edg[3]) begin
        if (credits >= 2) sub = 2;
      end
    end
    c = int'(credits) + add - sub;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    credits = c[7:0];
    mem[4'd0 ^ swap] = 4'((credits / 10) & 15);
    mem[4'd1 ^ swap] = 4'(credits % 10);
    mem[4'd2 ^ swap] = add[3:0];
    mem[4'd3 ^ swap] = sub[3:0];
    mem[4] = lo_pins(r.port_b);
    mem[5] = {1'b0, val[2], 1'b0, val[0]} << 1 | (edg & 4'h5);
    mem[6] = lo_pins(r.port_c);
    mem[7] = (val & 4'hA) | ((edg & 4'hA) >> 1);
  endfunction

  function automatic void load_coinage();
    coin_ratio[0] = mem[9];
    credit_ratio[0] = mem[10];
    coin_ratio[1] = mem[11];
    credit_ratio[1] = mem[12];
  endfunction

  function automatic void read_dips(host_req_t r);
    logic [7:0] p [4];
    p = '{r.port_a, r.port_b, r.port_c, r.port_d};
    for (int i = 0; i < 4; i++) begin
      mem[2 * i] = lo_pins(p[i]);
      mem[2 * i + 1] = hi_pins(p[i]);
    end
  endfunction

  function automatic void lfsr_check();
    logic [7:0] seed, rng;
    logic [3:0] acc;
    int cnt;
    seed = LFSR_SEED;
    cnt = (int'(mem[9]) * 16 + int'(mem[10])) & 8'h7F;
    for (int i = 0; i < cnt; i++) seed = lfsr_step(seed);
    for (int i = 1; i < 8; i++) begin
      acc = '0;
      rng = seed;
      for (int j = 0; j < 7; j++) begin
        if (j > 0) rng = lfsr_step(rng);
        if (j == 1) seed = rng;
        if (rng[0]) acc = acc ^ ~mem[lfsr_tap(3'(j))];
      end
      mem[i] = ~acc;
    end
    mem[0] = (mem[9] == 4'hF) ? 4'hF : 4'h0;
  endfunction

  // Predict the response of one request and advance the model
  function automatic host_resp_t predict_resp(host_req_t r);
    host_resp_t o;
    logic [7:0] sum;
    o = '0;
    case (r.func)
      FUNC_WRITE: mem[r.offset] = r.wdata;
      FUNC_READ: o.rdata = 8'hF0 | mem[r.offset];
      FUNC_RUN: begin
        if (variant == CHIP_56) begin
          case (mem[8])
            CMD56_SWITCH: begin
              mem[0] = lo_pins(r.port_a); mem[1] = lo_pins(r.port_b);
              mem[2] = lo_pins(r.port_c); mem[3] = lo_pins(r.port_d);
              o.out_a_valid = 1'b1; o.out_a = mem[9];
              o.out_b_valid = 1'b1; o.out_b = mem[10];
            end
            CMD56_COINAGE: load_coinage();
            CMD56_COINS: update_coins(r, 4'd0);
            CMD56_BOOT: begin
              mem[2] = BOOT_NIB2; mem[7] = BOOT_NIB7;
            end
            CMD56_CSUM: begin
              sum = '0;
              for (int i = 9; i < 16; i++) sum = sum + mem[i];
              mem[0] = sum[7:4]; mem[1] = sum[3:0];
            end
            CMD56_DIPS: begin
              read_dips(r); o.out_a_valid = 1'b1; o.out_a = 4'd1;
            end
            default: ;
          endcase
        end else if (variant == CHIP_58) begin
          case (mem[8])
            CMD58_SWITCH: begin
              mem[4] = lo_pins(r.port_a); mem[5] = lo_pins(r.port_b);
              mem[6] = lo_pins(r.port_c); mem[7] = lo_pins(r.port_d);
              o.out_a_valid = 1'b1; o.out_a = mem[9];
              o.out_b_valid = 1'b1; o.out_b = mem[10];
            end
            CMD58_COINAGE: load_coinage();
            CMD58_COINS: update_coins(r, 4'd2);
            CMD58_DIPS: begin
              read_dips(r); o.out_a_valid = 1'b1; o.out_a = 4'd1;
            end
            CMD58_LFSR: lfsr_check();
            default: ;
          endcase
        end else if (variant == CHIP_59 && mem[8] == CMD59_PORTS) begin
          mem[4] = lo_pins(r.port_a); mem[5] = lo_pins(r.port_c);
          mem[6] = lo_pins(r.port_b); mem[7] = lo_pins(r.port_d);
        end
      end
      FUNC_RSTON: begin
        line_rst = 1'b1;
        clear_coinage();
      end
      FUNC_RSTOF: line_rst = 1'b0;
      default: ;
    endcase
    o.reset_flag = line_rst;
    return o;
  endfunction

  function automatic host_req_t make_req(logic [2:0] f, logic [3:0] off, logic [3:0] wd);
    host_req_t r;
    r.func = f;
    r.offset = off;
    r.wdata = wd;
    r.port_a = 8'($urandom_range(0, 255));
    r.port_b = 8'($urandom_range(0, 255));
    r.port_c = 8'($urandom_range(0, 255));
    r.port_d = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Send request: drive on the falling edge, predict on acceptance
  always @(negedge clk) begin
    bit taken;
    taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        expected_resps.push_back(predict_resp(pending_reqs[0]));
        if (pending_reqs[0].func == FUNC_RUN) cmd_runs++;
        void'(pending_reqs.pop_front());
        taken = 1'b1;
      end
      // Hold an offered request until it is taken
      if (!s_tvalid || taken) begin
        if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 13)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {{(InWidth - $bits(host_req_t)){1'b0}}, pending_reqs[0]};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Capture ready at the rising edge so acceptance is judged on sampled values
  always @(posedge clk) s_tready_q <= s_tready;

  // Response side: sample at the rising edge, compare against the oldest prediction
  always @(posedge clk) begin
    host_resp_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(host_resp_t)-1:0];
      if (expected_resps.size() == 0) begin
        $error("unexpected response %h", got);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        resp_count++;
        if (got.rdata !== want.rdata) begin
          $error("rdata expected %h actual %h", want.rdata, got.rdata); errors++;
        end
        if (got.out_a_valid !== want.out_a_valid) begin
          $error("out_a_valid expected %b actual %b", want.out_a_valid, got.out_a_valid);
          errors++;
        end
        if (got.out_a !== want.out_a) begin
          $error("out_a expected %h actual %h", want.out_a, got.out_a); errors++;
        end
        if (got.out_b_valid !== want.out_b_valid) begin
          $error("out_b_valid expected %b actual %b", want.out_b_valid, got.out_b_valid);
          errors++;
        end
        if (got.out_b !== want.out_b) begin
          $error("out_b expected %h actual %h", want.out_b, got.out_b); errors++;
        end
        if (got.reset_flag !== want.reset_flag) begin
          $error("reset_flag expected %b actual %b", want.reset_flag, got.reset_flag);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (long_hold) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 200) begin
        long_hold <= 1'b0;
        hold_cnt <= 0;
      end
    end else begin
      m_tready <= quiet_phase || ($urandom_range(0, 99) >= 13);
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_variant(logic [1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    variant = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queue a well-formed command: set nibble 8 and operands, run, read back
  task automatic queue_command(logic [3:0] cmd);
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd8, cmd));
    for (int i = 9; i < 16; i++)
      if ($urandom_range(0, 2) == 0)
        pending_reqs.push_back(make_req(FUNC_WRITE, 4'(i), 4'($urandom_range(0, 15))));
    pending_reqs.push_back(make_req(FUNC_RUN, 4'($urandom), 4'($urandom)));
    for (int i = 0; i < 3; i++)
      pending_reqs.push_back(make_req(FUNC_READ, 4'($urandom), 4'($urandom)));
  endtask

  task automatic random_phase(int n);
    int q;
    logic [2:0] f;
    q = 0;
    while (q < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          queue_command(4'($urandom_range(0, 15) < 12 ? $urandom_range(1, 9)
                                                       : $urandom_range(0, 15)));
          q += 7;
        end
        5: begin
          // Run burst: repeated runs of the current command with changing pins
          for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(FUNC_RUN, 4'($urandom), 4'($urandom)));
          q += 6;
        end
        default: begin
          f = 3'($urandom_range(0, 7));
          pending_reqs.push_back(make_req(f, 4'($urandom), 4'($urandom)));
          q++;
        end
      endcase
      while (pending_reqs.size() > 40) @(posedge clk);
    end
  endtask

  initial begin
    host_req_t r;
    variant = CHIP_56;
    line_rst = 1'b0;
    prev_coins = '0;
    prev_buttons = '0;
    for (int i = 0; i < 16; i++) mem[i] = '0;
    clear_coinage();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, unused func codes
    quiet_phase = 1;
    pending_reqs.push_back(make_req(FUNC_READ, 4'd15, 4'd0));
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd0, 4'd15));
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd15, 4'd15));
    pending_reqs.push_back(make_req(FUNC_READ, 4'd0, 4'd0));
    pending_reqs.push_back(make_req(FUNC_READ, 4'd15, 4'd0));
    pending_reqs.push_back(make_req(FUNC_RSTON, 4'd0, 4'd0));
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd8, CMD56_SWITCH));
    pending_reqs.push_back(make_req(FUNC_RUN, 4'd0, 4'd0));
    pending_reqs.push_back(make_req(FUNC_RSTOF, 4'd0, 4'd0));
    for (int f = 5; f < 8; f++) pending_reqs.push_back(make_req(3'(f), 4'd3, 4'd9));
    r = make_req(FUNC_RUN, 4'd0, 4'd0);
    r.port_a = 8'h00; r.port_b = 8'hFF; r.port_c = 8'h0F; r.port_d = 8'hF0;
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd8, CMD56_DIPS));
    pending_reqs.push_back(r);
    r.port_a = 8'hFF; r.port_b = 8'h00; r.port_c = 8'hF0; r.port_d = 8'h0F;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(FUNC_WRITE, 4'd8, CMD56_CSUM));
    pending_reqs.push_back(make_req(FUNC_RUN, 4'd0, 4'd0));
    pending_reqs.push_back(make_req(FUNC_READ, 4'd1, 4'd0));
    wait_drained();
    quiet_phase = 0;

    // Random phases over every variant, the extremes included
    write_variant(CHIP_56);
    long_hold = 1;
    random_phase(350);
    wait_drained();
    write_variant(CHIP_58);
    random_phase(400);
    wait_drained();
    write_variant(CHIP_59);
    random_phase(200);
    wait_drained();
    write_variant(2'd3);
    random_phase(60);
    wait_drained();
    write_variant(CHIP_56);
    quiet_phase = 1;
    random_phase(120);
    quiet_phase = 0;
    wait_drained();
    write_variant(CHIP_58);
    random_phase(120);
    wait_drained();

    $display("Covered %0d responses, %0d command runs over all chip variants.",
             resp_count, cmd_runs);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
